>>> hw/rtl/hcbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbt_pkg: shared types and constants of the HSV color blob tracker
// Holds frame geometry, word layouts, operation and class codes and the
// state encodings of the front and back parts.
// ----------------------------------------------------------------------------
package hcbt_pkg;

  // Frame geometry and background store size.
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);

  // Divider geometry: numerators fit in 17 bits, divisors in 8 bits.
  localparam int NUM_W     = 17;
  localparam int DEN_W     = 8;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int HUE_FULL  = 360;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FG_THR     = 3'd0,
    REG_SWORD_LO   = 3'd1,
    REG_SWORD_HI   = 3'd2,
    REG_SWORD_SAT  = 3'd3,
    REG_MIN_BRIGHT = 3'd4,
    REG_SHIELD_LO  = 3'd5,
    REG_SHIELD_HI  = 3'd6,
    REG_SHIELD_SAT = 3'd7
  } reg_idx_t;

  localparam logic [6:0] RST_FG_THR     = 7'd25;
  localparam logic [8:0] RST_SWORD_LO   = 9'd15;
  localparam logic [8:0] RST_SWORD_HI   = 9'd345;
  localparam logic [6:0] RST_SWORD_SAT  = 7'd75;
  localparam logic [6:0] RST_MIN_BRIGHT = 7'd75;
  localparam logic [8:0] RST_SHIELD_LO  = 9'd105;
  localparam logic [8:0] RST_SHIELD_HI  = 9'd135;
  localparam logic [6:0] RST_SHIELD_SAT = 7'd50;

  // Operation codes; the fourth code does nothing but report HSV.
  localparam logic [1:0] OP_STORE    = 2'd0;
  localparam logic [1:0] OP_AVERAGE  = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  // Pixel class codes.
  localparam logic [1:0] CLS_BACKGROUND = 2'd0;
  localparam logic [1:0] CLS_FOREGROUND = 2'd1;
  localparam logic [1:0] CLS_SHIELD     = 2'd2;

  typedef struct packed {
    logic [6:0] fg_value_threshold;
    logic [8:0] sword_hue_low;
    logic [8:0] sword_hue_high;
    logic [6:0] sword_min_sat;
    logic [6:0] min_brightness;
    logic [8:0] shield_hue_low;
    logic [8:0] shield_hue_high;
    logic [6:0] shield_min_sat;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] col;
    logic [8:0] row;
    logic       frame_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  pixel_class;
    logic        sword_pixel;
    logic [8:0]  hue;
    logic [6:0]  saturation;
    logic [6:0]  brightness;
    logic        totals_valid;
    logic [18:0] red_count;
    logic [27:0] red_sum_x;
    logic [27:0] red_sum_y;
    logic [18:0] green_count;
    logic [27:0] green_sum_x;
    logic [27:0] green_sum_y;
  } out_word_t;

  // Word passed from the front to the back through the queue.
  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] col;
    logic [8:0] row;
    logic       frame_last;
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } mid_word_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_START,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_EXEC,
    B_HOLD
  } back_state_t;

endpackage

>>> hw/rtl/hcbt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbt_div: bit-serial restoring divider
// Divides a 17-bit numerator by a nonzero 8-bit divisor, one quotient bit
// per cycle; the low nine quotient bits are returned.
// ----------------------------------------------------------------------------
module hcbt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hcbt_pkg::NUM_W-1:0] num,
  input  logic [hcbt_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [8:0]                quo
);
  import hcbt_pkg::*;

  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next numerator bit and try to subtract.
  assign trial = {rem, acc[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  // Quotient bits replace the numerator bits as they shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

  assign quo = acc[8:0];

endmodule

>>> hw/rtl/hcbt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbt_fifo: two-entry queue between front and back
// Lets the HSV front and the classify back stall independently.
// ----------------------------------------------------------------------------
module hcbt_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  hcbt_pkg::mid_word_t wr_word,
  input  logic                rd,
  output hcbt_pkg::mid_word_t rd_word,
  output hcbt_pkg::q_stat_t   stat
);
  import hcbt_pkg::*;

  mid_word_t  slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_word;
    end
  end

  assign rd_word    = slots[rptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

>>> hw/rtl/hcbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbt_front: pixel intake and RGB to HSV conversion
// Latches one pixel, runs saturation and hue divisions in parallel and
// pushes the converted word into the queue.
// ----------------------------------------------------------------------------
module hcbt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hcbt_pkg::in_word_t  pixel,
  input  hcbt_pkg::q_stat_t   q_stat,
  output logic                q_wr,
  output hcbt_pkg::mid_word_t q_word
);
  import hcbt_pkg::*;

  front_state_t state;
  front_state_t state_next;
  in_word_t     cur;
  logic         div_start;
  logic         sat_busy;
  logic         hue_busy;
  logic [8:0]   sat_quo;
  logic [8:0]   hue_quo;

  logic [7:0]   mx;
  logic [7:0]   mn;
  logic [7:0]   d;
  logic         red_max;
  logic         green_max;
  logic         red_neg;
  logic [16:0]  hue_num;
  logic [16:0]  sat_num;
  logic [15:0]  v_scaled;
  logic [15:0]  v_round;
  logic [8:0]   hue;
  logic [6:0]   saturation;
  logic [6:0]   brightness;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (push) state_next = F_START;
      F_START: state_next = F_DIV;
      F_DIV:   if (!sat_busy && !hue_busy) state_next = F_PUSH;
      F_PUSH:  if (!q_stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full      = 1'b1;
    div_start = 1'b0;
    q_wr      = 1'b0;
    case (state)
      F_IDLE:  full = 1'b0;
      F_START: div_start = 1'b1;
      F_DIV:   ;
      F_PUSH:  q_wr = !q_stat.full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      cur <= pixel;
    end
  end

  // Extremes of the color components and hue branch selection.
  always_comb begin
    mx = cur.red;
    mn = cur.red;
    if (cur.green > mx) mx = cur.green;
    if (cur.blue > mx) mx = cur.blue;
    if (cur.green < mn) mn = cur.green;
    if (cur.blue < mn) mn = cur.blue;
    d         = mx - mn;
    red_max   = (mx == cur.red);
    green_max = (mx == cur.green);
    red_neg   = (cur.green < cur.blue);
  end

  // Division numerators; all are nonnegative and fit in 17 bits.
  always_comb begin
    sat_num = 17'(d) * 17'd100;
    if (red_max && !red_neg) begin
      hue_num = 17'(cur.green - cur.blue) * 17'd60;
    end else if (red_max) begin
      hue_num = 17'(cur.blue - cur.green) * 17'd60 + 17'(d) - 17'd1;
    end else if (green_max) begin
      hue_num = 17'(d) * 17'd120 + 17'(cur.blue) * 17'd60 - 17'(cur.red) * 17'd60;
    end else begin
      hue_num = 17'(d) * 17'd240 + 17'(cur.red) * 17'd60 - 17'(cur.green) * 17'd60;
    end
  end

  hcbt_div u_sat_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sat_num),
    .den   (mx),
    .busy  (sat_busy),
    .quo   (sat_quo)
  );

  hcbt_div u_hue_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (hue_num),
    .den   (d),
    .busy  (hue_busy),
    .quo   (hue_quo)
  );

  // Value is 100*max/255 by reciprocal: x/255 = (x + x/256 + 1)/256 for 16-bit x below 65535.
  assign v_scaled   = 16'(mx) * 16'd100;
  assign v_round    = v_scaled + {8'd0, v_scaled[15:8]} + 16'd1;
  assign brightness = v_round[14:8];

  // Final hue and saturation with the gray and black cases.
  always_comb begin
    if (d == 8'd0) begin
      hue = '0;
    end else if (red_max && red_neg) begin
      hue = 9'(HUE_FULL) - hue_quo;
    end else begin
      hue = hue_quo;
    end
    saturation = (mx == 8'd0) ? 7'd0 : sat_quo[6:0];
  end

  always_comb begin
    q_word.operation  = cur.operation;
    q_word.col        = cur.col;
    q_word.row        = cur.row;
    q_word.frame_last = cur.frame_last;
    q_word.hue        = hue;
    q_word.saturation = saturation;
    q_word.brightness = brightness;
  end

endmodule

>>> hw/rtl/hcbt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbt_back: background store, classification and blob totals
// Takes converted words from the queue, updates or compares the per-pixel
// background value, accumulates sword and shield sums and holds the result.
// ----------------------------------------------------------------------------
module hcbt_back (
  input  logic                clk,
  input  logic                rst,
  input  hcbt_pkg::cfg_t      cfg,
  input  hcbt_pkg::q_stat_t   q_stat,
  input  hcbt_pkg::mid_word_t q_word,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output hcbt_pkg::out_word_t result
);
  import hcbt_pkg::*;

  back_state_t     state;
  back_state_t     state_next;
  mid_word_t       cur;
  logic [6:0]      bg_mem [FRAME_PIXELS];
  logic [6:0]      bg_rd;
  logic            in_frame;
  logic [ADDR_W-1:0] addr;
  logic            exec;

  logic [18:0]     sw_cnt;
  logic [27:0]     sw_x;
  logic [27:0]     sw_y;
  logic [18:0]     sh_cnt;
  logic [27:0]     sh_x;
  logic [27:0]     sh_y;
  logic [18:0]     sw_cnt_next;
  logic [27:0]     sw_x_next;
  logic [27:0]     sw_y_next;
  logic [18:0]     sh_cnt_next;
  logic [27:0]     sh_x_next;
  logic [27:0]     sh_y_next;

  logic [6:0]      bg;
  logic [6:0]      dv;
  logic [7:0]      avg_sum;
  logic            is_classify;
  logic            fg_hit;
  logic            shield_hit;
  logic            sword_hit;
  logic            totals;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_stat.empty) state_next = B_FETCH;
      B_FETCH: state_next = B_EXEC;
      B_EXEC:  state_next = B_HOLD;
      B_HOLD:  if (pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_rd  = 1'b0;
    exec  = 1'b0;
    empty = 1'b1;
    case (state)
      B_IDLE:  q_rd = !q_stat.empty;
      B_FETCH: ;
      B_EXEC:  exec = 1'b1;
      B_HOLD:  empty = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_word;
    end
  end

  // Store address; pixels outside the frame never write the store and see a zero background.
  assign in_frame = (cur.col < 10'(FRAME_WIDTH)) && (cur.row < 9'(FRAME_HEIGHT));
  assign addr     = ADDR_W'(cur.row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(cur.col);

  // Background store: registered read, write in the execute cycle.
  always_ff @(posedge clk) begin
    if (state == B_FETCH) begin
      bg_rd <= bg_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (exec && in_frame && cur.operation == OP_STORE) begin
      bg_mem[addr] <= cur.brightness;
    end else if (exec && in_frame && cur.operation == OP_AVERAGE) begin
      bg_mem[addr] <= avg_sum[7:1];
    end
  end

  // Classification against the background and the color bands.
  always_comb begin
    bg          = in_frame ? bg_rd : 7'd0;
    avg_sum     = {1'b0, bg} + {1'b0, cur.brightness};
    dv          = (cur.brightness > bg) ? cur.brightness - bg : bg - cur.brightness;
    is_classify = (cur.operation == OP_CLASSIFY);
    fg_hit      = dv > cfg.fg_value_threshold;
    shield_hit  = is_classify && (cur.hue > cfg.shield_hue_low)
                  && (cur.hue < cfg.shield_hue_high)
                  && (cur.saturation > cfg.shield_min_sat)
                  && (cur.brightness > cfg.min_brightness);
    sword_hit   = is_classify
                  && ((cur.hue < cfg.sword_hue_low) || (cur.hue > cfg.sword_hue_high))
                  && (cur.saturation > cfg.sword_min_sat)
                  && (cur.brightness > cfg.min_brightness);
    totals      = is_classify && cur.frame_last;
  end

  // Accumulators including this pixel.
  always_comb begin
    sw_cnt_next = sw_cnt + 19'(sword_hit);
    sw_x_next   = sw_x + (sword_hit ? 28'(cur.col) : 28'd0);
    sw_y_next   = sw_y + (sword_hit ? 28'(cur.row) : 28'd0);
    sh_cnt_next = sh_cnt + 19'(shield_hit);
    sh_x_next   = sh_x + (shield_hit ? 28'(cur.col) : 28'd0);
    sh_y_next   = sh_y + (shield_hit ? 28'(cur.row) : 28'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_cnt <= '0;
      sw_x   <= '0;
      sw_y   <= '0;
      sh_cnt <= '0;
      sh_x   <= '0;
      sh_y   <= '0;
    end else if (exec && totals) begin
      sw_cnt <= '0;
      sw_x   <= '0;
      sw_y   <= '0;
      sh_cnt <= '0;
      sh_x   <= '0;
      sh_y   <= '0;
    end else if (exec) begin
      sw_cnt <= sw_cnt_next;
      sw_x   <= sw_x_next;
      sw_y   <= sw_y_next;
      sh_cnt <= sh_cnt_next;
      sh_x   <= sh_x_next;
      sh_y   <= sh_y_next;
    end
  end

  // Result word, held until popped.
  always_ff @(posedge clk) begin
    if (exec) begin
      if (shield_hit) begin
        result.pixel_class <= CLS_SHIELD;
      end else if (is_classify && fg_hit) begin
        result.pixel_class <= CLS_FOREGROUND;
      end else begin
        result.pixel_class <= CLS_BACKGROUND;
      end
      result.sword_pixel  <= sword_hit;
      result.hue          <= cur.hue;
      result.saturation   <= cur.saturation;
      result.brightness   <= cur.brightness;
      result.totals_valid <= totals;
      result.red_count    <= totals ? sw_cnt_next : '0;
      result.red_sum_x    <= totals ? sw_x_next : '0;
      result.red_sum_y    <= totals ? sw_y_next : '0;
      result.green_count  <= totals ? sh_cnt_next : '0;
      result.green_sum_x  <= totals ? sh_x_next : '0;
      result.green_sum_y  <= totals ? sh_y_next : '0;
    end
  end

endmodule

>>> hw/rtl/hsv_color_blob_tracker_unit.sv
`timescale 1ns / 1ps
// A pushed pixel passes the front, the queue and the back before it shows;
// the front takes no new pixel until the last is queued, so while results
// are popped its bit-serial hue and saturation dividers set the pixel rate.
// Reset (rst, synchronous) empties the queue, clears the sums and loads the
// register defaults; the background store is not cleared and holds junk
// until written.
// ----------------------------------------------------------------------------
// hsv_color_blob_tracker_unit: HSV color blob tracker top level
// Register file, front converter, queue and classify back end.
// ----------------------------------------------------------------------------
module hsv_color_blob_tracker_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  hcbt_pkg::in_word_t  pixel,
  output logic                empty,
  input  logic                pop,
  output hcbt_pkg::out_word_t result
);
  import hcbt_pkg::*;

  cfg_t      cfg;
  reg_idx_t  ridx;
  logic      cfg_wr;
  logic      q_wr;
  logic      q_rd;
  mid_word_t q_in;
  mid_word_t q_out;
  q_stat_t   q_stat;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_value_threshold <= RST_FG_THR;
      cfg.sword_hue_low      <= RST_SWORD_LO;
      cfg.sword_hue_high     <= RST_SWORD_HI;
      cfg.sword_min_sat      <= RST_SWORD_SAT;
      cfg.min_brightness     <= RST_MIN_BRIGHT;
      cfg.shield_hue_low     <= RST_SHIELD_LO;
      cfg.shield_hue_high    <= RST_SHIELD_HI;
      cfg.shield_min_sat     <= RST_SHIELD_SAT;
    end else if (cfg_wr) begin
      case (ridx)
        REG_FG_THR:     cfg.fg_value_threshold <= pwdata[6:0];
        REG_SWORD_LO:   cfg.sword_hue_low      <= pwdata[8:0];
        REG_SWORD_HI:   cfg.sword_hue_high     <= pwdata[8:0];
        REG_SWORD_SAT:  cfg.sword_min_sat      <= pwdata[6:0];
        REG_MIN_BRIGHT: cfg.min_brightness     <= pwdata[6:0];
        REG_SHIELD_LO:  cfg.shield_hue_low     <= pwdata[8:0];
        REG_SHIELD_HI:  cfg.shield_hue_high    <= pwdata[8:0];
        REG_SHIELD_SAT: cfg.shield_min_sat     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (ridx)
      REG_FG_THR:     prdata = 32'(cfg.fg_value_threshold);
      REG_SWORD_LO:   prdata = 32'(cfg.sword_hue_low);
      REG_SWORD_HI:   prdata = 32'(cfg.sword_hue_high);
      REG_SWORD_SAT:  prdata = 32'(cfg.sword_min_sat);
      REG_MIN_BRIGHT: prdata = 32'(cfg.min_brightness);
      REG_SHIELD_LO:  prdata = 32'(cfg.shield_hue_low);
      REG_SHIELD_HI:  prdata = 32'(cfg.shield_hue_high);
      REG_SHIELD_SAT: prdata = 32'(cfg.shield_min_sat);
      default:        prdata = '0;
    endcase
  end

  hcbt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_stat (q_stat),
    .q_wr   (q_wr),
    .q_word (q_in)
  );

  hcbt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_word (q_in),
    .rd      (q_rd),
    .rd_word (q_out),
    .stat    (q_stat)
  );

  hcbt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_word (q_out),
    .q_rd   (q_rd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // The front never writes a full queue and the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_stat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_stat.empty) else $error("queue read while empty");

  // Totals are zero on every word that carries no frame report.
  a_totals_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.totals_valid) |-> (result.red_count == '0
      && result.green_count == '0)) else $error("totals without report");

  // Saturation and value stay in percent range and hue below 360 on every shown word.
  a_hsv_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.saturation <= 7'd100 && result.brightness <= 7'd100
      && result.hue < 9'(HUE_FULL))) else $error("HSV out of range");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the HSV color blob tracker unit
// Streams pixels through the learn, average and classify passes under a
// series of register settings. A local HSV and classify predictor sets up the
// expected words, and every word that is popped is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import hcbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  in_word_t    pixel = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_word_t   result;

  hsv_color_blob_tracker_unit uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .pixel(pixel), .empty(empty), .pop(pop),
    .result(result)
  );

  always #2 clk = ~clk;

  // Predictor state: register copy, background store and blob sums.
  cfg_t        cfg_shadow;
  logic [6:0]  bg_store [int];
  bit          bg_written [int];
  logic [18:0] sword_cnt, shield_cnt;
  logic [27:0] sword_x, sword_y, shield_x, shield_y;

  in_word_t  pixel_queue [$];
  out_word_t expected_words [$];
  int        error_count = 0;
  int        idle_cycles = 0;

  // Integer HSV conversion with truncated quotients.
  task automatic compute_hsv(input int r, input int g, input int b,
                             output int h, output int s, output int v);
    int mx, mn, d;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = (mx * 100) / 255;
    s = (mx == 0) ? 0 : (d * 100) / mx;
    if (d == 0) h = 0;
    else if (mx == r) h = (g >= b) ? (60 * (g - b)) / d : 360 - (60 * (b - g) + d - 1) / d;
    else if (mx == g) h = (120 * d + 60 * b - 60 * r) / d;
    else h = (240 * d + 60 * r - 60 * g) / d;
  endtask

  // Works out the word that one accepted pixel produces and updates state.
  task automatic track_pixel(input in_word_t px);
    out_word_t w;
    int h, s, v, bg, addr, dv;
    bit in_frame;
    w = '0;
    compute_hsv(px.red, px.green, px.blue, h, s, v);
    in_frame = (px.col < FRAME_WIDTH) && (px.row < FRAME_HEIGHT);
    addr = px.row * FRAME_WIDTH + px.col;
    bg = (in_frame && bg_store.exists(addr)) ? bg_store[addr] : 0;
    w.hue = h;
    w.saturation = s;
    w.brightness = v;
    w.pixel_class = CLS_BACKGROUND;
    if (px.operation == OP_STORE) begin
      if (in_frame) bg_store[addr] = v;
    end else if (px.operation == OP_AVERAGE) begin
      if (in_frame) bg_store[addr] = (bg + v) >> 1;
    end else if (px.operation == OP_CLASSIFY) begin
      dv = (v > bg) ? v - bg : bg - v;
      if (dv > cfg_shadow.fg_value_threshold) w.pixel_class = CLS_FOREGROUND;
      if (h > cfg_shadow.shield_hue_low && h < cfg_shadow.shield_hue_high &&
          s > cfg_shadow.shield_min_sat && v > cfg_shadow.min_brightness) begin
        w.pixel_class = CLS_SHIELD;
        shield_cnt += 1;
        shield_x += px.col;
        shield_y += px.row;
      end
      if ((h < cfg_shadow.sword_hue_low || h > cfg_shadow.sword_hue_high) &&
          s > cfg_shadow.sword_min_sat && v > cfg_shadow.min_brightness) begin
        w.sword_pixel = 1'b1;
        sword_cnt += 1;
        sword_x += px.col;
        sword_y += px.row;
      end
      if (px.frame_last) begin
        w.totals_valid = 1'b1;
        w.red_count = sword_cnt;   w.red_sum_x = sword_x;    w.red_sum_y = sword_y;
        w.green_count = shield_cnt; w.green_sum_x = shield_x; w.green_sum_y = shield_y;
        sword_cnt = '0; sword_x = '0; sword_y = '0;
        shield_cnt = '0; shield_x = '0; shield_y = '0;
      end
    end
    expected_words.push_back(w);
  endtask

  task automatic check_field(input string name, input longint exp_val,
                             input longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Sender: offers queued pixels with random gaps, or back to back in bursts.
  int gap_left = 0;
  int sent_count = 0;
  always @(posedge clk) begin
    logic next_push;
    if (rst) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        track_pixel(pixel);
        sent_count++;
        next_push = 1'b0;
        gap_left = ((sent_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 7);
      end
      if (!next_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_queue.size() > 0) begin
          pixel <= pixel_queue.pop_front();
          next_push = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  // Receiver: random stalls, bursts without stalls, and one long hold-off.
  int stall_left = 0;
  int popped_count = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    out_word_t w;
    logic next_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      next_pop = pop;
      if (pop && !empty) begin
        popped_count++;
        if (expected_words.size() == 0) begin
          $error("word popped with nothing expected");
          error_count++;
        end else begin
          w = expected_words.pop_front();
          check_field("pixel_class", w.pixel_class, result.pixel_class);
          check_field("sword_pixel", w.sword_pixel, result.sword_pixel);
          check_field("hue", w.hue, result.hue);
          check_field("saturation", w.saturation, result.saturation);
          check_field("brightness", w.brightness, result.brightness);
          check_field("totals_valid", w.totals_valid, result.totals_valid);
          check_field("red_count", w.red_count, result.red_count);
          check_field("red_sum_x", w.red_sum_x, result.red_sum_x);
          check_field("red_sum_y", w.red_sum_y, result.red_sum_y);
          check_field("green_count", w.green_count, result.green_count);
          check_field("green_sum_x", w.green_sum_x, result.green_sum_x);
          check_field("green_sum_y", w.green_sum_y, result.green_sum_y);
        end
        next_pop = 1'b0;
        if (popped_count == 300 && !long_hold_done) begin
          long_hold_done = 1'b1;
          stall_left = HOLD_CYCLES;
        end else begin
          stall_left = ((popped_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
        end
      end
      if (!next_pop) begin
        if (stall_left > 0) stall_left--;
        else next_pop = 1'b1;
      end
      pop <= next_pop;
    end
  end

  // Watchdog on cycles without any accepted word or register write.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hsv_color_blob_tracker_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write over the configuration port; updates the local copy.
  task automatic write_reg(input reg_idx_t idx, input int value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FG_THR:     cfg_shadow.fg_value_threshold = value;
      REG_SWORD_LO:   cfg_shadow.sword_hue_low = value;
      REG_SWORD_HI:   cfg_shadow.sword_hue_high = value;
      REG_SWORD_SAT:  cfg_shadow.sword_min_sat = value;
      REG_MIN_BRIGHT: cfg_shadow.min_brightness = value;
      REG_SHIELD_LO:  cfg_shadow.shield_hue_low = value;
      REG_SHIELD_HI:  cfg_shadow.shield_hue_high = value;
      REG_SHIELD_SAT: cfg_shadow.shield_min_sat = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input int thr, input int sw_lo, input int sw_hi,
                           input int sw_sat, input int bright, input int sh_lo,
                           input int sh_hi, input int sh_sat);
    write_reg(REG_FG_THR, thr);
    write_reg(REG_SWORD_LO, sw_lo);
    write_reg(REG_SWORD_HI, sw_hi);
    write_reg(REG_SWORD_SAT, sw_sat);
    write_reg(REG_MIN_BRIGHT, bright);
    write_reg(REG_SHIELD_LO, sh_lo);
    write_reg(REG_SHIELD_HI, sh_hi);
    write_reg(REG_SHIELD_SAT, sh_sat);
  endtask

  // Queues a pixel; an in-frame read of a never-written background entry becomes a store.
  task automatic add_pixel(input logic [1:0] op, input int r, input int g,
                           input int b, input int c, input int rw, input bit last);
    in_word_t px;
    int addr;
    bit in_frame;
    in_frame = (c < FRAME_WIDTH) && (rw < FRAME_HEIGHT);
    addr = rw * FRAME_WIDTH + c;
    if (in_frame && (op == OP_AVERAGE || op == OP_CLASSIFY) && !bg_written.exists(addr))
      op = OP_STORE;
    if (in_frame && (op == OP_STORE || op == OP_AVERAGE)) bg_written[addr] = 1'b1;
    px.operation = op; px.red = r; px.green = g; px.blue = b;
    px.col = c; px.row = rw; px.frame_last = last;
    pixel_queue.push_back(px);
  endtask

  // Colors leaning toward saturated primaries so the bands get hit often.
  task automatic pick_color(output int r, output int g, output int b);
    int mode;
    mode = $urandom_range(0, 5);
    r = $urandom_range(0, 255); g = $urandom_range(0, 255); b = $urandom_range(0, 255);
    case (mode)
      0: begin g = r; b = r; end
      1: begin r = $urandom_range(200, 255); g = $urandom_range(0, 60); b = $urandom_range(0, 60); end
      2: begin g = $urandom_range(200, 255); r = $urandom_range(0, 90); b = $urandom_range(0, 90); end
      3: begin b = $urandom_range(180, 255); r = $urandom_range(0, 120); end
      default: ;
    endcase
  endtask

  // One frame: learn the region, maybe average it, then classify with noise.
  task automatic add_frame();
    int col_base, row_base, n, r, g, b, c, rw, k;
    col_base = ($urandom_range(0, 3) == 0) ? 632 : $urandom_range(0, 20);
    row_base = ($urandom_range(0, 3) == 0) ? 472 : $urandom_range(0, 10);
    n = $urandom_range(4, 12);
    for (k = 0; k < n; k++) begin
      pick_color(r, g, b);
      add_pixel(OP_STORE, r, g, b, col_base + k % 8, row_base + k / 8,
                $urandom_range(0, 9) == 0);
    end
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < n; k++) begin
        pick_color(r, g, b);
        add_pixel(OP_AVERAGE, r, g, b, col_base + k % 8, row_base + k / 8, 1'b0);
      end
    end
    for (k = 0; k < n + 4; k++) begin
      pick_color(r, g, b);
      if ($urandom_range(0, 9) == 0) begin
        c = $urandom_range(0, 1023); rw = $urandom_range(0, 511);
        add_pixel($urandom_range(0, 3), r, g, b, c, rw, $urandom_range(0, 1));
      end else begin
        add_pixel(OP_CLASSIFY, r, g, b, col_base + k % 8, row_base + (k / 8) % 2,
                  k == n + 3);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || push || expected_words.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int target;
    target = pixel_queue.size() + count;
    while (pixel_queue.size() < target) add_frame();
    wait_drained();
  endtask

  initial begin
    cfg_shadow = '{RST_FG_THR, RST_SWORD_LO, RST_SWORD_HI, RST_SWORD_SAT,
                   RST_MIN_BRIGHT, RST_SHIELD_LO, RST_SHIELD_HI, RST_SHIELD_SAT};
    sword_cnt = '0; sword_x = '0; sword_y = '0;
    shield_cnt = '0; shield_x = '0; shield_y = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset settings.
    add_pixel(OP_STORE, 0, 0, 0, 0, 0, 1'b0);
    add_pixel(OP_AVERAGE, 255, 255, 255, 0, 0, 1'b0);
    add_pixel(OP_STORE, 255, 255, 255, 639, 479, 1'b1);
    add_pixel(OP_CLASSIFY, 0, 0, 0, 0, 0, 1'b0);
    add_pixel(OP_CLASSIFY, 255, 255, 255, 0, 0, 1'b0);
    add_pixel(OP_CLASSIFY, 255, 0, 0, 639, 479, 1'b0);
    add_pixel(OP_CLASSIFY, 0, 255, 0, 0, 0, 1'b0);
    add_pixel(OP_CLASSIFY, 0, 0, 255, 639, 479, 1'b0);
    add_pixel(OP_CLASSIFY, 255, 0, 10, 0, 0, 1'b0);
    add_pixel(OP_CLASSIFY, 255, 255, 0, 0, 0, 1'b0);
    add_pixel(OP_CLASSIFY, 0, 255, 255, 639, 479, 1'b0);
    add_pixel(OP_CLASSIFY, 250, 20, 30, 1023, 511, 1'b0);
    add_pixel(OP_STORE, 10, 200, 30, 1023, 511, 1'b1);
    add_pixel(OP_AVERAGE, 10, 200, 30, 700, 3, 1'b0);
    add_pixel(2'd3, 170, 85, 5, 0, 0, 1'b1);
    add_pixel(OP_CLASSIFY, 20, 220, 40, 0, 0, 1'b1);
    add_pixel(OP_CLASSIFY, 1, 0, 0, 639, 479, 1'b1);
    wait_drained();

    random_phase(210);
    write_all($urandom_range(0, 100), $urandom_range(0, 359), $urandom_range(0, 359),
              $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 359),
              $urandom_range(0, 359), $urandom_range(0, 100));
    random_phase(210);
    write_all(0, 0, 0, 0, 0, 0, 359, 0);
    random_phase(200);
    write_all(100, 359, 359, 100, 100, 359, 359, 100);
    random_phase(200);
    write_all(10, 30, 330, 40, 40, 90, 150, 30);
    random_phase(200);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("hsv_color_blob_tracker_unit test passed");
    end else begin
      $display("hsv_color_blob_tracker_unit test failed");
    end
    $finish;
  end

endmodule
